// ===== sv/frame_delimiter_timing_monitor_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Frame delimiter timing monitor: assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef FRAME_DELIMITER_TIMING_MONITOR_UNIT_MACROS_SVH
`define FRAME_DELIMITER_TIMING_MONITOR_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FDTM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FDTM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fdtm_pkg.sv =====
// ----------------------------------------------------------------------------
// fdtm_pkg
// Types and constants of the frame delimiter timing monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package fdtm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CH_WB,
        ST_ACC_RD,
        ST_ACC_WB,
        ST_RD_WB,
        ST_CLR
    } state_t;

    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CLS_DROP,
        CLS_EVENT,
        CLS_READ,
        CLS_CLEAR
    } cls_t;

    localparam logic KIND_SOF = 1'b0;
    localparam logic KIND_EOF = 1'b1;

    localparam logic [2:0] GRP_XFER   = 3'd0;
    localparam logic [2:0] GRP_PERIOD = 3'd1;
    localparam logic [2:0] GRP_INTER  = 3'd2;
    localparam logic [2:0] GRP_INTRA  = 3'd3;
    localparam logic [2:0] GRP_DIR    = 3'd4;

    localparam logic REG_MASK  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam logic [3:0]  MASK_RESET  = 4'h3;
    localparam logic [15:0] LIMIT_RESET = 16'd1024;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    localparam int IN_USER_W  = 6;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 344;

    typedef struct packed {
        logic [63:0] sum;
        logic [31:0] max;
        logic [31:0] min;
        logic [31:0] count;
    } acc_t;

    localparam acc_t ACC_EMPTY = '{sum: 64'd0, max: 32'd0, min: ALL_ONES, count: 32'd0};

    typedef struct packed {
        logic [31:0] ends;
        logic [31:0] starts;
        logic [31:0] frames;
        logic [31:0] last_start;
        logic [31:0] open_start;
    } chan_t;

    typedef struct packed {
        logic pop;
        logic ch_wb;
        logic acc_rd;
        logic acc_wb;
        logic res_load;
        logic clr_wr;
        logic clr_start;
    } ctrl_t;

endpackage

`default_nettype wire

// ===== sv/fdtm_ram.sv =====
// ----------------------------------------------------------------------------
// fdtm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fdtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/fdtm_acc_alu.sv =====
// ----------------------------------------------------------------------------
// fdtm_acc_alu
// Folds one time sample into a count/min/max/sum accumulator record.
// ----------------------------------------------------------------------------
`default_nettype none

module fdtm_acc_alu (
    input  wire fdtm_pkg::acc_t cur,
    input  wire logic [31:0]    sample,
    output fdtm_pkg::acc_t      upd
);

    always_comb begin
        upd.count = cur.count + 32'd1;
        upd.min   = (sample < cur.min) ? sample : cur.min;
        upd.max   = (sample > cur.max) ? sample : cur.max;
        upd.sum   = cur.sum + {32'd0, sample};
    end

endmodule

`default_nettype wire

// ===== sv/fdtm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdtm_ctrl
// Sequencer: dispatch, channel write-back, accumulator passes, read, clear.
// ----------------------------------------------------------------------------
`default_nettype none

module fdtm_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         buf_valid,
    input  wire fdtm_pkg::cls_t cls,
    input  wire logic         ops_new,
    input  wire logic         ops_left,
    input  wire logic         out_free,
    input  wire logic         clr_last,
    output fdtm_pkg::ctrl_t   ctl
);

    fdtm_pkg::state_t state_reg;
    fdtm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fdtm_pkg::ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fdtm_pkg::ST_IDLE: begin
                if (buf_valid) begin
                    case (cls)
                        fdtm_pkg::CLS_EVENT: state_next = fdtm_pkg::ST_CH_WB;
                        fdtm_pkg::CLS_READ:  state_next = fdtm_pkg::ST_RD_WB;
                        fdtm_pkg::CLS_CLEAR: state_next = fdtm_pkg::ST_CLR;
                        default:             state_next = fdtm_pkg::ST_IDLE;
                    endcase
                end
            end
            fdtm_pkg::ST_CH_WB:
                state_next = ops_new ? fdtm_pkg::ST_ACC_RD : fdtm_pkg::ST_IDLE;
            fdtm_pkg::ST_ACC_RD:
                state_next = fdtm_pkg::ST_ACC_WB;
            fdtm_pkg::ST_ACC_WB:
                state_next = ops_left ? fdtm_pkg::ST_ACC_RD : fdtm_pkg::ST_IDLE;
            fdtm_pkg::ST_RD_WB:
                state_next = out_free ? fdtm_pkg::ST_IDLE : fdtm_pkg::ST_RD_WB;
            fdtm_pkg::ST_CLR:
                state_next = clr_last ? fdtm_pkg::ST_IDLE : fdtm_pkg::ST_CLR;
            default:
                state_next = fdtm_pkg::ST_CLR;
        endcase
    end

    always_comb begin
        ctl           = '0;
        ctl.pop       = (state_reg == fdtm_pkg::ST_IDLE) && buf_valid;
        ctl.clr_start = ctl.pop && (cls == fdtm_pkg::CLS_CLEAR);
        ctl.ch_wb     = (state_reg == fdtm_pkg::ST_CH_WB);
        ctl.acc_rd    = (state_reg == fdtm_pkg::ST_ACC_RD);
        ctl.acc_wb    = (state_reg == fdtm_pkg::ST_ACC_WB);
        ctl.res_load  = (state_reg == fdtm_pkg::ST_RD_WB) && out_free;
        ctl.clr_wr    = (state_reg == fdtm_pkg::ST_CLR);
    end

endmodule

`default_nettype wire

// ===== sv/frame_delimiter_timing_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// frame_delimiter_timing_monitor_unit
// Per-channel frame timing statistics over timestamped start/end delimiters.
// ----------------------------------------------------------------------------
// Input stream (s_*) carries one command per transfer: a delimiter event, a
// statistics read or a clear. Only a read produces a transfer on the result
// stream (m_*). Registers channel_mask and event_limit sit on the APB port.
// An input skid register takes the next command while the current one runs,
// except during a clear sweep. Each updated accumulator takes one
// read-modify-write pass through the accumulator RAM (read, then write-back):
//   read: item read at dispatch, result load held by any output stall
//   end of frame: channel write-back, then a duration pass if a frame was open
//   start of frame: channel write-back, then period, gap and directional gap passes
//   clear: dispatch plus a sweep over the channel and accumulator RAMs
// After reset the same sweep runs with s_tready low. A stalled result holds
// in the output register; the next command is still taken into the skid
// register and processed up to its own result.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_delimiter_timing_monitor_unit #(
    parameter int CHANNELS = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // tdata: channel[1:0], stamp[33:2], to_channel[35:34], zero pad
    input  wire logic [fdtm_pkg::IN_DATA_W-1:0]    s_tdata,
    // tuser: opcode[1:0], kind[2], stat_group[5:3]
    input  wire logic [fdtm_pkg::IN_USER_W-1:0]    s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata: stat_count[31:0], stat_min[63:32], stat_max[95:64],
    // stat_sum[159:96], frames_done[191:160], starts_seen[223:192],
    // ends_seen[255:224], overlap_count[287:256], repeat_runs[319:288],
    // events_taken[335:320], capped[336], zero pad
    output logic [fdtm_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int CW        = $clog2(CHANNELS);
    localparam int ACC_DEPTH = 2 * CHANNELS + 2 + CHANNELS * CHANNELS;
    localparam int AW        = $clog2(ACC_DEPTH);
    localparam int PW        = $clog2(CHANNELS + 1);
    localparam logic [AW-1:0] A_PERIOD = AW'(CHANNELS);
    localparam logic [AW-1:0] A_INTER  = AW'(2 * CHANNELS);
    localparam logic [AW-1:0] A_INTRA  = AW'(2 * CHANNELS + 1);
    localparam logic [AW-1:0] A_DIR    = AW'(2 * CHANNELS + 2);
    localparam logic [AW-1:0] A_LAST   = AW'(ACC_DEPTH - 1);

    // configuration
    logic [3:0]  mask_reg;
    logic [15:0] limit_reg;

    // skid register
    logic        buf_valid_reg;
    logic [1:0]  buf_opcode_reg;
    logic [1:0]  buf_ch_reg;
    logic        buf_kind_reg;
    logic [31:0] buf_stamp_reg;
    logic [2:0]  buf_grp_reg;
    logic [1:0]  buf_to_reg;

    // current command
    logic [CW-1:0] cur_ch_reg;
    logic          cur_kind_reg;
    logic [31:0]   cur_stamp_reg;
    logic          cur_ch_ok_reg;
    logic          cur_empty_reg;

    // global state
    logic [CHANNELS-1:0] open_reg;
    logic [CHANNELS-1:0] lsv_reg;
    logic                prev_valid_reg;
    logic [31:0]         prev_stamp_reg;
    logic [CW-1:0]       prev_ch_reg;
    logic                prev_kind_reg;
    logic                done_valid_reg;
    logic [CW-1:0]       done_ch_reg;
    logic [31:0]         overlap_reg;
    logic [31:0]         repeat_reg;
    logic [15:0]         taken_reg;

    // accumulator pass list
    logic [2:0]    pend_reg;
    logic [AW-1:0] op_addr_reg [3];
    logic [31:0]   op_val_reg  [3];
    logic [1:0]    cur_op_reg;
    logic [AW-1:0] clr_cnt_reg;

    // output
    logic                            m_valid_reg;
    logic [fdtm_pkg::OUT_DATA_W-1:0] m_data_reg;

    fdtm_pkg::ctrl_t ctl;
    fdtm_pkg::cls_t  cls;
    fdtm_pkg::acc_t  acc_rdata;
    fdtm_pkg::acc_t  acc_wdata;
    fdtm_pkg::acc_t  acc_upd;
    fdtm_pkg::acc_t  res_acc;
    fdtm_pkg::chan_t ch_rdata;
    fdtm_pkg::chan_t ch_wdata;
    fdtm_pkg::chan_t rec_next;
    fdtm_pkg::chan_t res_ch;

    logic          buf_ch_ok;
    logic          buf_to_ok;
    logic [CW-1:0] buf_ch_idx;
    logic [CW-1:0] buf_to_idx;
    logic [AW-1:0] rd_item_addr;
    logic          rd_item_empty;
    logic          acc_we;
    logic [AW-1:0] acc_waddr;
    logic          acc_re;
    logic [AW-1:0] acc_raddr;
    logic          ch_we;
    logic [CW-1:0] ch_waddr;
    logic          ch_re;
    logic [1:0]    op_sel;
    logic          ops_left;
    logic          out_free;
    logic          clr_last;
    logic          capped_now;
    logic          analyse;
    logic          is_start;
    logic          gap_v;
    logic          intra;
    logic [2:0]    ops_new;
    logic [AW-1:0] addr_new [3];
    logic [31:0]   val_new  [3];
    logic [PW-1:0] open_others;
    logic          cfg_wr;

    function automatic logic [AW-1:0] dir_addr(input logic [CW-1:0] from_ch,
                                               input logic [CW-1:0] to_ch);
        logic [AW-1:0] row;
        row = AW'(from_ch) * AW'(CHANNELS);
        return A_DIR + row + AW'(to_ch);
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= fdtm_pkg::MASK_RESET;
            limit_reg <= fdtm_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == fdtm_pkg::REG_LIMIT) begin
                limit_reg <= pwdata[15:0];
            end else begin
                mask_reg <= pwdata[3:0];
            end
        end
    end

    assign prdata = (paddr[2] == fdtm_pkg::REG_LIMIT) ? {16'd0, limit_reg}
                                                      : {28'd0, mask_reg};

    // ------------------------------------------------------------------
    // skid register and dispatch decode
    // ------------------------------------------------------------------
    assign s_tready = !buf_valid_reg && !ctl.clr_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            buf_valid_reg <= 1'b1;
        end else if (ctl.pop) begin
            buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            buf_opcode_reg <= s_tuser[1:0];
            buf_kind_reg   <= s_tuser[2];
            buf_grp_reg    <= s_tuser[5:3];
            buf_ch_reg     <= s_tdata[1:0];
            buf_stamp_reg  <= s_tdata[33:2];
            buf_to_reg     <= s_tdata[35:34];
        end
    end

    assign buf_ch_ok  = 32'(buf_ch_reg) < CHANNELS;
    assign buf_to_ok  = 32'(buf_to_reg) < CHANNELS;
    assign buf_ch_idx = CW'(buf_ch_reg);
    assign buf_to_idx = CW'(buf_to_reg);

    always_comb begin
        case (fdtm_pkg::opcode_t'(buf_opcode_reg))
            fdtm_pkg::OP_EVENT:
                cls = (buf_ch_ok && mask_reg[buf_ch_reg]) ? fdtm_pkg::CLS_EVENT
                                                           : fdtm_pkg::CLS_DROP;
            fdtm_pkg::OP_READ:  cls = fdtm_pkg::CLS_READ;
            fdtm_pkg::OP_CLEAR: cls = fdtm_pkg::CLS_CLEAR;
            default:            cls = fdtm_pkg::CLS_DROP;
        endcase
    end

    always_comb begin
        rd_item_addr  = '0;
        rd_item_empty = 1'b0;
        case (buf_grp_reg)
            fdtm_pkg::GRP_XFER: begin
                rd_item_addr  = AW'(buf_ch_idx);
                rd_item_empty = !buf_ch_ok;
            end
            fdtm_pkg::GRP_PERIOD: begin
                rd_item_addr  = A_PERIOD + AW'(buf_ch_idx);
                rd_item_empty = !buf_ch_ok;
            end
            fdtm_pkg::GRP_INTER: rd_item_addr = A_INTER;
            fdtm_pkg::GRP_INTRA: rd_item_addr = A_INTRA;
            fdtm_pkg::GRP_DIR: begin
                rd_item_addr  = dir_addr(buf_ch_idx, buf_to_idx);
                rd_item_empty = !(buf_ch_ok && buf_to_ok);
            end
            default: rd_item_empty = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.pop) begin
            cur_ch_reg    <= buf_ch_idx;
            cur_kind_reg  <= buf_kind_reg;
            cur_stamp_reg <= buf_stamp_reg;
            cur_ch_ok_reg <= buf_ch_ok;
            cur_empty_reg <= rd_item_empty;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    fdtm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .buf_valid (buf_valid_reg),
        .cls       (cls),
        .ops_new   (ops_new != 3'd0),
        .ops_left  (ops_left),
        .out_free  (out_free),
        .clr_last  (clr_last),
        .ctl       (ctl)
    );

    // ------------------------------------------------------------------
    // channel record RAM
    // ------------------------------------------------------------------
    assign ch_re    = ctl.pop && buf_ch_ok
                      && (cls == fdtm_pkg::CLS_EVENT || cls == fdtm_pkg::CLS_READ);
    assign ch_we    = ctl.ch_wb || (ctl.clr_wr && (clr_cnt_reg < AW'(CHANNELS)));
    assign ch_waddr = ctl.clr_wr ? clr_cnt_reg[CW-1:0] : cur_ch_reg;
    assign ch_wdata = ctl.clr_wr ? '0 : rec_next;

    fdtm_ram #(
        .WIDTH ($bits(fdtm_pkg::chan_t)),
        .DEPTH (CHANNELS)
    ) u_ch_ram (
        .aclk  (aclk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .re    (ch_re),
        .raddr (buf_ch_idx),
        .rdata (ch_rdata)
    );

    // ------------------------------------------------------------------
    // event analysis during channel write-back
    // ------------------------------------------------------------------
    assign capped_now = taken_reg >= limit_reg;
    assign analyse    = !capped_now;
    assign is_start   = (cur_kind_reg == fdtm_pkg::KIND_SOF);
    assign gap_v      = prev_valid_reg && (prev_kind_reg == fdtm_pkg::KIND_EOF);
    assign intra      = (prev_ch_reg == cur_ch_reg);

    always_comb begin
        open_others = '0;
        for (int o = 0; o < CHANNELS; o++) begin
            if (CW'(o) != cur_ch_reg && open_reg[o]) begin
                open_others = open_others + PW'(1);
            end
        end
    end

    always_comb begin
        rec_next = ch_rdata;
        if (is_start) begin
            rec_next.starts = ch_rdata.starts + 32'd1;
        end else begin
            rec_next.ends = ch_rdata.ends + 32'd1;
        end
        if (analyse && is_start) begin
            rec_next.last_start = cur_stamp_reg;
            rec_next.open_start = cur_stamp_reg;
        end
        if (analyse && !is_start && open_reg[cur_ch_reg]) begin
            rec_next.frames = ch_rdata.frames + 32'd1;
        end

        ops_new[0]  = analyse && (is_start ? lsv_reg[cur_ch_reg] : open_reg[cur_ch_reg]);
        addr_new[0] = is_start ? (A_PERIOD + AW'(cur_ch_reg)) : AW'(cur_ch_reg);
        val_new[0]  = cur_stamp_reg - (is_start ? ch_rdata.last_start : ch_rdata.open_start);
        ops_new[1]  = analyse && is_start && gap_v;
        addr_new[1] = intra ? A_INTRA : A_INTER;
        val_new[1]  = cur_stamp_reg - prev_stamp_reg;
        ops_new[2]  = analyse && is_start && gap_v && !intra;
        addr_new[2] = dir_addr(prev_ch_reg, cur_ch_reg);
        val_new[2]  = cur_stamp_reg - prev_stamp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr_start) begin
            open_reg       <= '0;
            lsv_reg        <= '0;
            prev_valid_reg <= 1'b0;
            prev_stamp_reg <= '0;
            prev_ch_reg    <= '0;
            prev_kind_reg  <= fdtm_pkg::KIND_SOF;
            done_valid_reg <= 1'b0;
            done_ch_reg    <= '0;
            overlap_reg    <= '0;
            repeat_reg     <= '0;
            taken_reg      <= '0;
        end else if (ctl.ch_wb && analyse) begin
            taken_reg      <= taken_reg + 16'd1;
            prev_valid_reg <= 1'b1;
            prev_stamp_reg <= cur_stamp_reg;
            prev_ch_reg    <= cur_ch_reg;
            prev_kind_reg  <= cur_kind_reg;
            if (is_start) begin
                overlap_reg          <= overlap_reg + 32'(open_others);
                lsv_reg[cur_ch_reg]  <= 1'b1;
                open_reg[cur_ch_reg] <= 1'b1;
            end else if (open_reg[cur_ch_reg]) begin
                open_reg[cur_ch_reg] <= 1'b0;
                done_valid_reg       <= 1'b1;
                done_ch_reg          <= cur_ch_reg;
                if (done_valid_reg && done_ch_reg == cur_ch_reg) begin
                    repeat_reg <= repeat_reg + 32'd1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // accumulator passes
    // ------------------------------------------------------------------
    always_comb begin
        if (pend_reg[0]) begin
            op_sel = 2'd0;
        end else if (pend_reg[1]) begin
            op_sel = 2'd1;
        end else begin
            op_sel = 2'd2;
        end
    end

    assign ops_left = (pend_reg & ~(3'b001 << cur_op_reg)) != 3'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr_start) begin
            pend_reg <= '0;
        end else if (ctl.ch_wb) begin
            pend_reg <= ops_new;
        end else if (ctl.acc_wb) begin
            pend_reg <= pend_reg & ~(3'b001 << cur_op_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ch_wb) begin
            for (int i = 0; i < 3; i++) begin
                op_addr_reg[i] <= addr_new[i];
                op_val_reg[i]  <= val_new[i];
            end
        end
        if (ctl.acc_rd) begin
            cur_op_reg <= op_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr_start) begin
            clr_cnt_reg <= '0;
        end else if (ctl.clr_wr) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign clr_last = (clr_cnt_reg == A_LAST);

    fdtm_acc_alu u_alu (
        .cur    (acc_rdata),
        .sample (op_val_reg[cur_op_reg]),
        .upd    (acc_upd)
    );

    assign acc_re    = ctl.acc_rd || (ctl.pop && cls == fdtm_pkg::CLS_READ);
    assign acc_raddr = ctl.acc_rd ? op_addr_reg[op_sel] : rd_item_addr;
    assign acc_we    = ctl.acc_wb || ctl.clr_wr;
    assign acc_waddr = ctl.clr_wr ? clr_cnt_reg : op_addr_reg[cur_op_reg];
    assign acc_wdata = ctl.clr_wr ? fdtm_pkg::ACC_EMPTY : acc_upd;

    fdtm_ram #(
        .WIDTH ($bits(fdtm_pkg::acc_t)),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_tready;
    assign res_acc  = cur_empty_reg ? fdtm_pkg::ACC_EMPTY : acc_rdata;
    assign res_ch   = cur_ch_ok_reg ? ch_rdata : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.res_load) begin
            m_data_reg <= {7'd0, capped_now, taken_reg, repeat_reg, overlap_reg,
                           res_ch.ends, res_ch.starts, res_ch.frames,
                           res_acc.sum, res_acc.max, res_acc.min, res_acc.count};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/fdtm_checker.sv =====
// ----------------------------------------------------------------------------
// fdtm_checker
// Port-level checks on the result stream of the timing monitor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_delimiter_timing_monitor_unit_macros.svh"

module fdtm_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic [fdtm_pkg::OUT_DATA_W-1:0]    m_tdata,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready
);

    `FDTM_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result transfer dropped while stalled")
    `FDTM_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result data changed while stalled")
    `FDTM_ASSERT_SAME(a_empty_acc, aclk, aresetn, m_tvalid && (m_tdata[31:0] == 32'd0), (m_tdata[63:32] == fdtm_pkg::ALL_ONES) && (m_tdata[95:64] == 32'd0) && (m_tdata[159:96] == 64'd0), "empty accumulator has wrong min, max or sum")
    `FDTM_ASSERT_SAME(a_min_max, aclk, aresetn, m_tvalid && (m_tdata[31:0] != 32'd0), m_tdata[63:32] <= m_tdata[95:64], "accumulator min above max")

endmodule

bind frame_delimiter_timing_monitor_unit fdtm_checker u_fdtm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
